// ===== rtl/plid_pkg.sv =====
// Shared types and constants of the positional list insert/delete unit.
package plid_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CAPACITY_MAX = 1024;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int CNT_W        = 7;
  localparam int STAT_W       = 2;
  localparam int IDX_MAX_W    = $clog2(CAPACITY_MAX);

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                 ins_en;
    logic                 del_en;
    logic [IDX_MAX_W-1:0] idx;
    logic [DATA_W-1:0]    value;
  } cmd_t;

endpackage

// ===== rtl/plid_cell.sv =====
// One storage cell of the list row: holds one entry, shifts with its neighbors.
module plid_cell #(
  parameter int Index = 0
) (
  input  logic                       clk_i,
  input  plid_pkg::cmd_t             cmd_i,
  input  logic [plid_pkg::DATA_W-1:0] prev_i,
  input  logic [plid_pkg::DATA_W-1:0] next_i,
  output logic [plid_pkg::DATA_W-1:0] value_o,
  output logic [plid_pkg::DATA_W-1:0] tap_o
);

  localparam logic [plid_pkg::IDX_MAX_W-1:0] MyIdx = plid_pkg::IDX_MAX_W'(Index);

  logic [plid_pkg::DATA_W-1:0] entry_q, entry_d;
  logic                        hit;

  assign hit = (cmd_i.idx == MyIdx);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en) begin
      if (MyIdx > cmd_i.idx) begin
        entry_d = prev_i;
      end else if (hit) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.del_en) begin
      if (MyIdx >= cmd_i.idx) begin
        entry_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign value_o = entry_q;
  // masked read port, OR-combined at the top for the removed value
  assign tap_o   = hit ? entry_q : '0;

endmodule

// ===== rtl/positional_list_insert_delete_unit.sv =====
// Top level of the positional list insert/delete unit: control, cell row, result register.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+--------------------------------------------
//  in      | in  | in_valid_i / in_ready_o   | req_type_i, position_i, value_i
//  out     | out | out_valid_o / out_ready_i | status_o, removed_value_o, entry_count_o
//
// One request per cycle: the whole cell row shifts in the cycle of the input
// transfer and the result lands in the output register at that edge.
// in_ready_o is high while the result register is empty or being drained,
// so a waiting result stalls the input only when out_ready_i is low.
// Reset clears the entry count and the result valid flag; cell contents
// are undefined until written and are never read at or above the count.
module positional_list_insert_delete_unit #(
  parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [plid_pkg::POS_W-1:0]    position_i,
  input  logic signed [plid_pkg::DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [plid_pkg::STAT_W-1:0]   status_o,
  output logic signed [plid_pkg::DATA_W-1:0] removed_value_o,
  output logic [plid_pkg::CNT_W-1:0]    entry_count_o
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  // compare width: room for position, count and count + 1
  localparam int CMP_W = ((LEN_W > plid_pkg::POS_W) ? LEN_W : plid_pkg::POS_W) + 1;

  logic [LEN_W-1:0] len_q, len_d;
  logic             out_valid_q;
  logic [plid_pkg::STAT_W-1:0] status_q, status_d;
  logic [plid_pkg::DATA_W-1:0] removed_q, removed_d;
  logic [plid_pkg::CNT_W-1:0]  count_q;

  logic             in_xfer;
  logic [CMP_W-1:0] pos_ext, len_ext;
  logic             pos_nz, ins_pos_ok, del_pos_ok, full;
  logic [plid_pkg::POS_W-1:0] pos_m1;
  plid_pkg::cmd_t   cmd;

  logic [plid_pkg::DATA_W-1:0] cell_val [CAPACITY];
  logic [plid_pkg::DATA_W-1:0] cell_tap [CAPACITY];
  logic [plid_pkg::DATA_W-1:0] tap_or;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // ---- request check ----
  assign pos_ext    = CMP_W'(position_i);
  assign len_ext    = CMP_W'(len_q);
  assign pos_nz     = (position_i != '0);
  assign ins_pos_ok = pos_nz && (pos_ext <= len_ext + CMP_W'(1));
  assign del_pos_ok = pos_nz && (pos_ext <= len_ext);
  assign full       = (len_q == LEN_W'(CAPACITY));
  assign pos_m1     = position_i - plid_pkg::POS_W'(1);

  always_comb begin
    cmd.ins_en = 1'b0;
    cmd.del_en = 1'b0;
    cmd.idx    = plid_pkg::IDX_MAX_W'(pos_m1);
    cmd.value  = value_i;
    status_d   = plid_pkg::ST_DONE;
    removed_d  = '0;
    len_d      = len_q;
    if (req_type_i == plid_pkg::REQ_INSERT) begin
      if (!ins_pos_ok) begin
        status_d = plid_pkg::ST_BADPOS;
      end else if (full) begin
        status_d = plid_pkg::ST_FULL;
      end else begin
        cmd.ins_en = in_xfer;
        len_d      = len_q + LEN_W'(1);
      end
    end else begin
      if (!del_pos_ok) begin
        status_d = plid_pkg::ST_BADPOS;
      end else begin
        cmd.del_en = in_xfer;
        removed_d  = tap_or;
        len_d      = len_q - LEN_W'(1);
      end
    end
  end

  // ---- cell row: each inner cell sees its left and right neighbor ----
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [plid_pkg::DATA_W-1:0] prev_v, next_v;
    if (g == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid
      assign prev_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_v = cell_val[g];
    end else begin : g_inner
      assign next_v = cell_val[g+1];
    end
    plid_cell #(
      .Index(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .prev_i (prev_v),
      .next_i (next_v),
      .value_o(cell_val[g]),
      .tap_o  (cell_tap[g])
    );
  end

  // at most one cell matches the index, so OR gives its entry
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  // ---- state and result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        len_q <= len_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      count_q   <= plid_pkg::CNT_W'(len_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = count_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> count_q == plid_pkg::CNT_W'(len_q))
    else $error("reported count differs from stored count");

  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != plid_pkg::ST_DONE) |-> removed_q == '0)
    else $error("removed value nonzero on failed request");

  a_full_only_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == plid_pkg::ST_FULL) |-> len_q == LEN_W'(CAPACITY))
    else $error("full status below capacity");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> len_q == $past(len_q))
    else $error("count changed without a transfer");
`endif

endmodule
